FILE: rtl/mfsp_pkg.sv
`timescale 1ns / 1ps
package mfsp_pkg;
  typedef enum logic [12:0] {
    P_HID    = 13'b0000000000001,
    P_HSIZE  = 13'b0000000000010,
    P_HFIELD = 13'b0000000000100,
    P_SKIP   = 13'b0000000001000,
    P_CID    = 13'b0000000010000,
    P_CSIZE  = 13'b0000000100000,
    P_DELTA  = 13'b0000001000000,
    P_STATUS = 13'b0000010000000,
    P_META   = 13'b0000100000000,
    P_LEN    = 13'b0001000000000,
    P_DATA   = 13'b0010000000000,
    P_TRAIL  = 13'b0100000000000,
    P_ERR    = 13'b1000000000000
  } phase_t;

  localparam logic [3:0] ROLE_ID = 4'd0;
  localparam logic [3:0] ROLE_SIZE = 4'd1;
  localparam logic [3:0] ROLE_HDR = 4'd2;
  localparam logic [3:0] ROLE_SKIP = 4'd3;
  localparam logic [3:0] ROLE_DELTA = 4'd4;
  localparam logic [3:0] ROLE_STATUS = 4'd5;
  localparam logic [3:0] ROLE_META = 4'd6;
  localparam logic [3:0] ROLE_LEN = 4'd7;
  localparam logic [3:0] ROLE_DATA = 4'd8;
  localparam logic [3:0] ROLE_TRAIL = 4'd9;
  localparam logic [3:0] ROLE_IGN = 4'd10;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_HDR = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [31:0] ID_MTHD = 32'h4D546864;
  localparam logic [31:0] ID_MTRK = 32'h4D54726B;
  localparam logic [27:0] LEN_MAX = 28'hFFFFFFF;
  localparam logic [47:0] TIME_MAX = 48'hFFFFFFFFFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  byte_echo;
    logic        field_done;
    logic [31:0] field_value;
    logic [47:0] elapsed_ticks;
    logic [15:0] track_index;
    logic        in_track_chunk;
    logic [7:0]  event_status;
    logic [7:0]  meta_kind;
    logic        text_char;
    logic        track_end;
    logic [1:0]  error_code;
  } out_item_t;
endpackage

FILE: rtl/mfsp_in_if.sv
`timescale 1ns / 1ps
interface mfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       is_last;
  modport source (output valid, byte_in, is_last, input ready);
  modport sink (input valid, byte_in, is_last, output ready);
endinterface

FILE: rtl/mfsp_out_if.sv
`timescale 1ns / 1ps
interface mfsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [7:0]  byte_echo;
  logic        field_done;
  logic [31:0] field_value;
  logic [47:0] elapsed_ticks;
  logic [15:0] track_index;
  logic        in_track_chunk;
  logic [7:0]  event_status;
  logic [7:0]  meta_kind;
  logic        text_char;
  logic        track_end;
  logic [1:0]  error_code;
  modport source (output valid, byte_role, byte_echo, field_done, field_value, elapsed_ticks,
                  track_index, in_track_chunk, event_status, meta_kind, text_char,
                  track_end, error_code, input ready);
  modport sink (input valid, byte_role, byte_echo, field_done, field_value, elapsed_ticks,
                track_index, in_track_chunk, event_status, meta_kind, text_char,
                track_end, error_code, output ready);
endinterface

FILE: rtl/mfsp_fifo.sv
`timescale 1ns / 1ps
module mfsp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  mfsp_pkg::in_item_t    wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output mfsp_pkg::in_item_t    rd_data
);
  import mfsp_pkg::*;
  // two-entry queue between byte intake and the decoder
  in_item_t   mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wptr] <= wr_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= ~wptr;
      if (rd_valid && rd_ready) rptr <= ~rptr;
      count <= count + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule

FILE: rtl/mfsp_decoder.sv
`timescale 1ns / 1ps
module mfsp_decoder #(
  parameter int VLQ_MAX_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfsp_pkg::out_item_t out_data
);
  import mfsp_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  field_count, fc_next;
  logic [31:0] chunk_left, cl_next;
  logic [15:0] tracks_expected, te_next;
  logic [15:0] tracks_seen, ts_next;
  logic [31:0] vlq_accum, va_next;
  logic [47:0] time_accum, ta_next;
  logic [7:0]  status_hold, sh_next;
  logic [7:0]  meta_hold, mh_next;
  logic [27:0] data_left, dl_next;
  logic [2:0]  chunk_flags, cf_next;
  logic [1:0]  error_hold, eh_next;
  out_item_t   res;
  logic        fire;
  logic [7:0]  b;
  logic [31:0] vshift;
  logic [2:0]  fc_inc;
  logic        vlq_end;
  logic [48:0] tsum;
  logic [7:0]  id_byte;
  logic [31:0] id_word;
  logic        run;
  logic [3:0]  role;
  logic [31:0] dlen;
  logic        go_data;

  assign in_ready = !out_valid || out_ready;
  assign fire = in_valid && in_ready;
  assign b = in_data.data;
  assign fc_inc = field_count + 3'd1;
  assign vshift = {vlq_accum[24:0], b[6:0]};
  assign vlq_end = !b[7] || ({29'd0, fc_inc} >= 32'(VLQ_MAX_BYTES)) || fc_inc == 3'd0;
  assign id_word = (phase == P_HID) ? ID_MTHD : ID_MTRK;

  always_comb begin
    case (field_count[1:0])
      2'd0: id_byte = id_word[31:24];
      2'd1: id_byte = id_word[23:16];
      2'd2: id_byte = id_word[15:8];
      default: id_byte = id_word[7:0];
    endcase
  end

  always_comb begin
    phase_next = phase; fc_next = field_count; cl_next = chunk_left;
    te_next = tracks_expected; ts_next = tracks_seen; va_next = vlq_accum;
    ta_next = time_accum; sh_next = status_hold; mh_next = meta_hold;
    dl_next = data_left; cf_next = chunk_flags; eh_next = error_hold;
    res = '0;
    run = 1'b1;
    tsum = '0;
    dlen = '0;
    go_data = 1'b0;
    case (phase)
      P_HID, P_CID: role = ROLE_ID;
      P_HSIZE, P_CSIZE: role = ROLE_SIZE;
      P_HFIELD: role = ROLE_HDR;
      P_SKIP: role = ROLE_SKIP;
      P_DELTA: role = ROLE_DELTA;
      P_STATUS: role = ROLE_STATUS;
      P_META: role = ROLE_META;
      P_LEN: role = ROLE_LEN;
      P_DATA: role = ROLE_DATA;
      P_TRAIL: role = ROLE_TRAIL;
      default: role = ROLE_IGN;
    endcase

    if (error_hold != ERR_NONE || phase == P_ERR) begin
      role = ROLE_IGN; run = 1'b0;
    end else if (phase inside {P_DELTA, P_STATUS, P_META, P_LEN, P_DATA}) begin
      if (chunk_left == 32'd0) begin
        eh_next = ERR_TRUNC; phase_next = P_ERR; run = 1'b0;
      end else cl_next = chunk_left - 32'd1;
    end

    if (run) begin
      case (phase)
        P_HID, P_CID: begin
          if (phase == P_CID && field_count == 3'd0) cf_next = 3'd0;
          if (b != id_byte) cf_next[0] = 1'b1;
          fc_next = fc_inc;
          if (fc_inc >= 3'd4) begin
            if (phase == P_CID) begin
              if (!cf_next[0]) begin
                cf_next = 3'b010;
                ts_next = tracks_seen + 16'd1;
                ta_next = '0; sh_next = '0; mh_next = '0;
              end else cf_next = 3'd0;
              phase_next = P_CSIZE;
            end else phase_next = P_HSIZE;
            fc_next = 3'd0;
          end
        end
        P_HSIZE, P_CSIZE: begin
          va_next = (field_count == 3'd0) ? {24'd0, b} : {vlq_accum[23:0], b};
          fc_next = fc_inc;
          if (fc_inc >= 3'd4) begin
            res.field_done = 1'b1; res.field_value = va_next; fc_next = 3'd0;
            if (phase == P_HSIZE) begin
              if (chunk_flags[0] || va_next < 32'd6) begin
                eh_next = ERR_HDR; phase_next = P_ERR;
              end else begin
                cl_next = va_next - 32'd6; cf_next = 3'd0; phase_next = P_HFIELD;
              end
            end else begin
              cl_next = va_next;
              if (chunk_flags[1]) phase_next = P_DELTA;
              else if (va_next != 32'd0) phase_next = P_SKIP;
              else if (tracks_seen == tracks_expected) begin
                phase_next = P_TRAIL; cf_next = 3'd0;
              end else phase_next = P_CID;
            end
          end
        end
        P_HFIELD: begin
          if (!field_count[0]) va_next = {24'd0, b};
          else begin
            va_next = {16'd0, vlq_accum[7:0], b};
            res.field_done = 1'b1; res.field_value = va_next;
            if (field_count == 3'd3) te_next = va_next[15:0];
          end
          fc_next = fc_inc;
          if (fc_inc >= 3'd6) begin
            fc_next = 3'd0;
            if (chunk_left != 32'd0) phase_next = P_SKIP;
            else if (tracks_seen == tracks_expected) begin
              phase_next = P_TRAIL; cf_next = 3'd0;
            end else phase_next = P_CID;
          end
        end
        P_SKIP: begin
          if (chunk_left != 32'd0) cl_next = chunk_left - 32'd1;
          if (cl_next == 32'd0) begin
            fc_next = 3'd0;
            if (tracks_seen == tracks_expected) begin
              phase_next = P_TRAIL; cf_next = 3'd0;
            end else phase_next = P_CID;
          end
        end
        P_DELTA: begin
          va_next = (field_count == 3'd0) ? {25'd0, b[6:0]} : vshift;
          fc_next = fc_inc;
          if (vlq_end) begin
            res.field_done = 1'b1; res.field_value = va_next;
            tsum = {1'b0, time_accum} + {17'd0, va_next};
            ta_next = tsum[48] ? TIME_MAX : tsum[47:0];
            fc_next = 3'd0; phase_next = P_STATUS;
          end
        end
        P_STATUS: begin
          sh_next = b;
          go_data = 1'b1;
          case (b[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: dlen = 32'd2;
            4'hC, 4'hD: dlen = 32'd1;
            4'hF: begin
              if (b == 8'hF0 || b == 8'hF7) begin
                go_data = 1'b0; fc_next = 3'd0; phase_next = P_LEN;
              end else if (b == 8'hF2) dlen = 32'd2;
              else if (b == 8'hF3) dlen = 32'd1;
              else if (b == 8'hFF) begin
                go_data = 1'b0; phase_next = P_META;
              end
            end
            default: dlen = 32'd0;
          endcase
        end
        P_META: begin
          mh_next = b;
          if (b == 8'h2F) cf_next[2] = 1'b1;
          fc_next = 3'd0; phase_next = P_LEN;
        end
        P_LEN: begin
          va_next = (field_count == 3'd0) ? {25'd0, b[6:0]} : vshift;
          fc_next = fc_inc;
          if (vlq_end) begin
            res.field_done = 1'b1; res.field_value = va_next;
            fc_next = 3'd0;
            go_data = 1'b1; dlen = va_next;
          end
        end
        P_DATA: begin
          if (status_hold == 8'hFF && meta_hold >= 8'h01 && meta_hold <= 8'h07 &&
              b >= 8'h20 && b < 8'h7F) res.text_char = 1'b1;
          if (data_left != 28'd0) dl_next = data_left - 28'd1;
          if (dl_next == 28'd0) begin
            fc_next = 3'd0;
            if (chunk_flags[2]) begin
              cf_next[2] = 1'b0; res.track_end = 1'b1;
              if (cl_next != 32'd0) phase_next = P_SKIP;
              else if (tracks_seen == tracks_expected) begin
                phase_next = P_TRAIL; cf_next = 3'd0;
              end else phase_next = P_CID;
            end else phase_next = P_DELTA;
          end
        end
        default: ;
      endcase
      // begin data: zero length ends the event at once
      if (go_data) begin
        dl_next = (dlen > {4'd0, LEN_MAX}) ? LEN_MAX : dlen[27:0];
        if (dl_next == 28'd0) begin
          fc_next = 3'd0;
          if (cf_next[2]) begin
            cf_next[2] = 1'b0; res.track_end = 1'b1;
            if (cl_next != 32'd0) phase_next = P_SKIP;
            else if (ts_next == te_next) begin
              phase_next = P_TRAIL; cf_next = 3'd0;
            end else phase_next = P_CID;
          end else phase_next = P_DELTA;
        end else phase_next = P_DATA;
      end
    end

    if (in_data.last && eh_next == ERR_NONE && phase_next != P_TRAIL) begin
      eh_next = ERR_TRUNC; phase_next = P_ERR;
    end

    res.byte_role = role;
    res.byte_echo = b;
    res.elapsed_ticks = ta_next;
    res.track_index = cf_next[1] ? ts_next - 16'd1 : ts_next;
    res.in_track_chunk = cf_next[1];
    res.event_status = sh_next;
    res.meta_kind = (sh_next == 8'hFF) ? mh_next : 8'd0;
    res.error_code = eh_next;
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= res;
    if (rst) begin
      phase <= P_HID; field_count <= '0; chunk_left <= '0; tracks_expected <= '0;
      tracks_seen <= '0; vlq_accum <= '0; time_accum <= '0; status_hold <= '0;
      meta_hold <= '0; data_left <= '0; chunk_flags <= '0; error_hold <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase <= phase_next; field_count <= fc_next; chunk_left <= cl_next;
        tracks_expected <= te_next; tracks_seen <= ts_next; vlq_accum <= va_next;
        time_accum <= ta_next; status_hold <= sh_next; meta_hold <= mh_next;
        data_left <= dl_next; chunk_flags <= cf_next; error_hold <= eh_next;
      end
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

FILE: rtl/midi_file_stream_parser.sv
`timescale 1ns / 1ps
// Standard MIDI file byte parser, one byte per transaction.
// Path: an accepted byte enters a queue entry, then its result enters the decoder
// result register, from which it is valid and can be taken.
// Throughput: 1 byte per cycle unless output stalls; all decoder state updates at once.
// Reset (rst, synchronous): parser expects the header chunk id, all counters clear,
// queue and result register empty.
module midi_file_stream_parser #(
  parameter int VLQ_MAX_BYTES = 4
) (
  input logic       clk,
  input logic       rst,
  mfsp_in_if.sink   in_ch,
  mfsp_out_if.source out_ch
);
  import mfsp_pkg::*;
  in_item_t  q_in, q_out;
  out_item_t r;
  logic      q_valid, q_ready;

  assign q_in.data = in_ch.byte_in;
  assign q_in.last = in_ch.is_last;

  mfsp_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(q_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
  );

  mfsp_decoder #(.VLQ_MAX_BYTES(VLQ_MAX_BYTES)) u_dec (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_out),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(r)
  );

  assign out_ch.byte_role = r.byte_role;
  assign out_ch.byte_echo = r.byte_echo;
  assign out_ch.field_done = r.field_done;
  assign out_ch.field_value = r.field_value;
  assign out_ch.elapsed_ticks = r.elapsed_ticks;
  assign out_ch.track_index = r.track_index;
  assign out_ch.in_track_chunk = r.in_track_chunk;
  assign out_ch.event_status = r.event_status;
  assign out_ch.meta_kind = r.meta_kind;
  assign out_ch.text_char = r.text_char;
  assign out_ch.track_end = r.track_end;
  assign out_ch.error_code = r.error_code;
endmodule
